// ===== sv/rihs_pkg.sv =====
// ----------------------------------------------------------------------------
// rihs_pkg
// Shared constants, CORDIC angle table and flag type of the RGB to IHS
// pixel converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rihs_pkg;

    localparam int DEF_COMPONENT_BITS    = 8;
    localparam int DEF_HUE_FRACTION_BITS = 6;
    localparam int DEF_SAT_FRACTION_BITS = 4;

    // Vectoring iterations and the Q30 scale of the chroma vector
    localparam int CORDIC_STEPS = 30;
    localparam int Q30_SHIFT    = 30;
    localparam logic signed [32:0] SQRT3_Q30 = 33'sd1859775393;

    // Binary angles: a full turn is 2^32
    localparam logic [31:0] Z_HALF_TURN = 32'h8000_0000;
    localparam logic [31:0] ROUND_HALF  = 32'h8000_0000;

    localparam int HUE_DEGREES  = 360;
    localparam int HUE_INT_BITS = 9;

    // atan(2^-i) as a fraction of a full turn, scaled by 2^32
    localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // Per-pixel control bits that travel with the data
    typedef struct packed {
        logic valid;
        logic neg;   // vector pre-rotated by a half turn
        logic gray;  // red = green = blue
    } rihs_flags_t;

endpackage

`default_nettype wire

// ===== sv/rihs_front.sv =====
// ----------------------------------------------------------------------------
// rihs_front
// Three-stage front end: chroma vector, squared magnitude and intensity.
// ----------------------------------------------------------------------------
`default_nettype none

module rihs_front
    import rihs_pkg::*;
#(
    parameter int COMPONENT_BITS = DEF_COMPONENT_BITS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            en,
    input  wire logic                            in_valid,
    input  wire logic [COMPONENT_BITS-1:0]       red,
    input  wire logic [COMPONENT_BITS-1:0]       green,
    input  wire logic [COMPONENT_BITS-1:0]       blue,
    output rihs_flags_t                          flags,
    output logic signed [COMPONENT_BITS+33:0]    x0,
    output logic signed [COMPONENT_BITS+33:0]    y0,
    output logic [2*COMPONENT_BITS+1:0]          q,
    output logic [COMPONENT_BITS+1:0]            intensity
);

    localparam int CB       = COMPONENT_BITS;
    localparam int XW       = CB + 34;
    localparam int QW       = 2 * CB + 2;
    localparam int NW       = CB + 4;
    localparam int IW       = CB + 2;
    localparam int DivShift = NW + 2;
    localparam int PW       = NW + DivShift;
    localparam logic [DivShift-1:0] DivRecip = DivShift'((64'd1 << DivShift) / 64'd3);

    // Stage 1
    logic signed [CB+2:0] a_full;
    logic signed [CB+1:0] d_full;
    logic signed [CB+2:0] a_abs_full;
    logic signed [CB+1:0] d_adj_full;
    logic [CB+1:0]        sum;

    logic                 v1_reg, neg1_reg, gray1_reg;
    logic [CB:0]          abs_a1_reg;
    logic signed [CB:0]   dn1_reg;
    logic [NW-1:0]        n1_reg;

    // Stage 2
    logic                 v2_reg, neg2_reg, gray2_reg;
    logic signed [XW-1:0] x2_reg, y2_reg;
    logic [QW-1:0]        sqa2_reg, sqd2_reg;
    logic [NW-1:0]        n2_reg;
    logic [PW-1:0]        prod2_reg;
    logic signed [QW-1:0] sqd_full;

    // Stage 3
    logic                 v3_reg, neg3_reg, gray3_reg;
    logic signed [XW-1:0] x3_reg, y3_reg;
    logic [QW-1:0]        q3_reg;
    logic [IW-1:0]        int3_reg;
    logic [NW-1:0]        qe, rem3;

    always_comb begin
        a_full     = $signed({2'b00, blue, 1'b0}) - $signed({3'b000, red})
                   - $signed({3'b000, green});
        d_full     = $signed({2'b00, red}) - $signed({2'b00, green});
        a_abs_full = a_full[CB+2] ? -a_full : a_full;
        d_adj_full = a_full[CB+2] ? -d_full : d_full;
        sum        = (CB+2)'(red) + (CB+2)'(green) + (CB+2)'(blue);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg1_reg   <= a_full[CB+2];
            gray1_reg  <= (a_full == '0) && (d_full == '0);
            abs_a1_reg <= a_abs_full[CB:0];
            dn1_reg    <= d_adj_full[CB:0];
            n1_reg     <= {sum, 2'b00} + NW'(1);
        end
    end

    assign sqd_full = QW'(dn1_reg) * QW'(dn1_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            neg2_reg  <= neg1_reg;
            gray2_reg <= gray1_reg;
            x2_reg    <= $signed(XW'({abs_a1_reg, {Q30_SHIFT{1'b0}}}));
            y2_reg    <= XW'(dn1_reg) * SQRT3_Q30;
            sqa2_reg  <= QW'(abs_a1_reg) * QW'(abs_a1_reg);
            sqd2_reg  <= $unsigned(sqd_full);
            n2_reg    <= n1_reg;
            prod2_reg <= PW'(n1_reg) * PW'(DivRecip);
        end
    end

    // Reciprocal estimate is exact or one low; fix it with one compare
    always_comb begin
        qe   = prod2_reg[PW-1:DivShift];
        rem3 = n2_reg - (qe + (qe << 1));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg3_reg  <= neg2_reg;
            gray3_reg <= gray2_reg;
            x3_reg    <= x2_reg;
            y3_reg    <= y2_reg;
            q3_reg    <= sqa2_reg + sqd2_reg + (sqd2_reg << 1);
            int3_reg  <= (rem3 >= NW'(3)) ? IW'(qe + NW'(1)) : IW'(qe);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign flags     = '{valid: v3_reg, neg: neg3_reg, gray: gray3_reg};
    assign x0        = x3_reg;
    assign y0        = y3_reg;
    assign q         = q3_reg;
    assign intensity = int3_reg;

endmodule

`default_nettype wire

// ===== sv/rihs_cordic.sv =====
// ----------------------------------------------------------------------------
// rihs_cordic
// Pipelined CORDIC vectoring, one rotation per stage, then hue scaling
// and rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module rihs_cordic
    import rihs_pkg::*;
#(
    parameter int COMPONENT_BITS    = DEF_COMPONENT_BITS,
    parameter int HUE_FRACTION_BITS = DEF_HUE_FRACTION_BITS
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  en,
    input  wire rihs_flags_t                           flags,
    input  wire logic signed [COMPONENT_BITS+33:0]     x0,
    input  wire logic signed [COMPONENT_BITS+33:0]     y0,
    output logic                                       out_valid,
    output logic [HUE_INT_BITS+HUE_FRACTION_BITS-1:0]  hue
);

    localparam int XW = COMPONENT_BITS + 34;
    localparam int HW = HUE_INT_BITS + HUE_FRACTION_BITS;
    localparam int PW = 32 + HW;
    localparam logic [HW-1:0] HueFull = HW'(HUE_DEGREES << HUE_FRACTION_BITS);

    logic signed [XW-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [XW-1:0] y_reg [0:CORDIC_STEPS];
    logic [31:0]          z_reg [0:CORDIC_STEPS];
    logic                 g_reg [0:CORDIC_STEPS];
    logic                 v_reg [0:CORDIC_STEPS];

    logic signed [XW-1:0] x_next [CORDIC_STEPS];
    logic signed [XW-1:0] y_next [CORDIC_STEPS];
    logic [31:0]          z_next [CORDIC_STEPS];

    logic          v_h1_reg, g_h1_reg, v_out_reg;
    logic [PW-1:0] prod_h1_reg;
    logic [PW-1:0] rnd;
    logic [HW-1:0] hue_raw;
    logic [HW-1:0] hue_reg;

    // Rotate toward the x axis: positive y turns clockwise
    always_comb begin
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            if (!y_reg[k][XW-1] && (y_reg[k] != '0)) begin
                x_next[k] = x_reg[k] + (y_reg[k] >>> k);
                y_next[k] = y_reg[k] - (x_reg[k] >>> k);
                z_next[k] = z_reg[k] + ATAN_TURN[k];
            end else begin
                x_next[k] = x_reg[k] - (y_reg[k] >>> k);
                y_next[k] = y_reg[k] + (x_reg[k] >>> k);
                z_next[k] = z_reg[k] - ATAN_TURN[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= x0;
            y_reg[0] <= y0;
            z_reg[0] <= flags.neg ? Z_HALF_TURN : '0;
            g_reg[0] <= flags.gray;
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                x_reg[k+1] <= x_next[k];
                y_reg[k+1] <= y_next[k];
                z_reg[k+1] <= z_next[k];
                g_reg[k+1] <= g_reg[k];
            end
            prod_h1_reg <= PW'(z_reg[CORDIC_STEPS]) * PW'(HueFull);
            g_h1_reg    <= g_reg[CORDIC_STEPS];
            hue_reg     <= (g_h1_reg || (hue_raw >= HueFull)) ? '0 : hue_raw;
        end
    end

    // Round to nearest; a full turn wraps to zero
    always_comb begin
        rnd     = prod_h1_reg + PW'(ROUND_HALF);
        hue_raw = rnd[PW-1:32];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= CORDIC_STEPS; k++) begin
                v_reg[k] <= 1'b0;
            end
            v_h1_reg  <= 1'b0;
            v_out_reg <= 1'b0;
        end else if (en) begin
            v_reg[0] <= flags.valid;
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                v_reg[k+1] <= v_reg[k];
            end
            v_h1_reg  <= v_reg[CORDIC_STEPS];
            v_out_reg <= v_h1_reg;
        end
    end

    assign out_valid = v_out_reg;
    assign hue       = hue_reg;

endmodule

`default_nettype wire

// ===== sv/rihs_sqrt.sv =====
// ----------------------------------------------------------------------------
// rihs_sqrt
// Pipelined digit-by-digit square root of the scaled chroma energy,
// one result bit per stage, then round to nearest.
// ----------------------------------------------------------------------------
`default_nettype none

module rihs_sqrt
    import rihs_pkg::*;
#(
    parameter int COMPONENT_BITS    = DEF_COMPONENT_BITS,
    parameter int SAT_FRACTION_BITS = DEF_SAT_FRACTION_BITS
) (
    input  wire logic                                   aclk,
    input  wire logic                                   en,
    input  wire logic [2*COMPONENT_BITS+1:0]            q,
    output logic [COMPONENT_BITS+SAT_FRACTION_BITS-1:0] saturation
);

    localparam int QW = 2 * COMPONENT_BITS + 2;
    localparam int MW = QW + 2 * SAT_FRACTION_BITS;
    localparam int RS = MW / 2;
    localparam int SW = COMPONENT_BITS + SAT_FRACTION_BITS;

    logic [MW-1:0] rem_reg [0:RS];
    logic [MW-1:0] res_reg [0:RS];
    logic [MW-1:0] rem_next [RS];
    logic [MW-1:0] res_next [RS];
    logic [MW:0]   trial [RS];
    logic [MW-1:0] bit_k [RS];
    logic [RS:0]   rounded;
    logic [SW-1:0] sat_reg;

    always_comb begin
        for (int k = 0; k < RS; k++) begin
            bit_k[k] = MW'(1) << (MW - 2 - 2 * k);
            trial[k] = {1'b0, res_reg[k]} + {1'b0, bit_k[k]};
            if ({1'b0, rem_reg[k]} >= trial[k]) begin
                rem_next[k] = rem_reg[k] - trial[k][MW-1:0];
                res_next[k] = (res_reg[k] >> 1) + bit_k[k];
            end else begin
                rem_next[k] = rem_reg[k];
                res_next[k] = res_reg[k] >> 1;
            end
        end
        rounded = {1'b0, res_reg[RS][RS-1:0]} + (RS+1)'(1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= {q, {(2*SAT_FRACTION_BITS){1'b0}}};
            res_reg[0] <= '0;
            for (int k = 0; k < RS; k++) begin
                rem_reg[k+1] <= rem_next[k];
                res_reg[k+1] <= res_next[k];
            end
            sat_reg <= rounded[SW:1];
        end
    end

    assign saturation = sat_reg;

endmodule

`default_nettype wire

// ===== sv/rgb_to_ihs_pixel_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_ihs_pixel_converter
// Stateless RGB to intensity / hue / saturation converter, fully pipelined.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                     Payload (tdata, lowest bit first)
//  -------  ------------------------  --------------------------------------
//  input    s_tvalid s_tready s_tdata red, green, blue (zero padded to bytes)
//  output   m_tvalid m_tready m_tdata intensity, hue, saturation (padded)
//
//  One pixel per clock while the output is accepted. The latency does not depend on
//  COMPONENT_BITS: 3 front stages + 31 CORDIC stages (30 rotations plus the entry
//  register) + 2 hue scaling stages; the CORDIC rotation chain sets it.
//  Reset (aresetn low at a clock edge) clears every valid bit; data
//  registers keep whatever they hold.
//  When a result sits on the output unaccepted, the whole pipeline holds;
//  nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_ihs_pixel_converter
    import rihs_pkg::*;
#(
    parameter int COMPONENT_BITS    = DEF_COMPONENT_BITS,
    parameter int HUE_FRACTION_BITS = DEF_HUE_FRACTION_BITS,
    parameter int SAT_FRACTION_BITS = DEF_SAT_FRACTION_BITS
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // red, green, blue
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [((3*COMPONENT_BITS+7)/8)*8-1:0] s_tdata,
    // intensity, hue, saturation
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [((2*COMPONENT_BITS+HUE_INT_BITS+HUE_FRACTION_BITS
                    +SAT_FRACTION_BITS+2+7)/8)*8-1:0]  m_tdata
);

    localparam int CB        = COMPONENT_BITS;
    localparam int XW        = CB + 34;
    localparam int QW        = 2 * CB + 2;
    localparam int IW        = CB + 2;
    localparam int HW        = HUE_INT_BITS + HUE_FRACTION_BITS;
    localparam int SW        = CB + SAT_FRACTION_BITS;
    localparam int MDW       = ((IW + HW + SW + 7) / 8) * 8;
    localparam int CordicLat = CORDIC_STEPS + 3;
    localparam int RootLat   = (QW / 2 + SAT_FRACTION_BITS) + 2;
    localparam int SatDly    = CordicLat - RootLat;
    localparam int IntDly    = CordicLat;

    logic                 en;
    rihs_flags_t          front_flags;
    logic signed [XW-1:0] x0, y0;
    logic [QW-1:0]        q;
    logic [IW-1:0]        intensity;
    logic [HW-1:0]        hue;
    logic [SW-1:0]        saturation;
    logic                 cordic_valid;

    logic [IW-1:0] int_dly_reg [IntDly];
    logic [SW-1:0] sat_dly_reg [SatDly];

    // Advance everything unless a result is held at the output
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    rihs_front #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .red       (s_tdata[CB-1:0]),
        .green     (s_tdata[2*CB-1:CB]),
        .blue      (s_tdata[3*CB-1:2*CB]),
        .flags     (front_flags),
        .x0        (x0),
        .y0        (y0),
        .q         (q),
        .intensity (intensity)
    );

    rihs_cordic #(
        .COMPONENT_BITS    (COMPONENT_BITS),
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .flags     (front_flags),
        .x0        (x0),
        .y0        (y0),
        .out_valid (cordic_valid),
        .hue       (hue)
    );

    rihs_sqrt #(
        .COMPONENT_BITS    (COMPONENT_BITS),
        .SAT_FRACTION_BITS (SAT_FRACTION_BITS)
    ) u_sqrt (
        .aclk       (aclk),
        .en         (en),
        .q          (q),
        .saturation (saturation)
    );

    // Align intensity and saturation with the longer hue path
    always_ff @(posedge aclk) begin
        if (en) begin
            int_dly_reg[0] <= intensity;
            for (int k = 1; k < IntDly; k++) begin
                int_dly_reg[k] <= int_dly_reg[k-1];
            end
            sat_dly_reg[0] <= saturation;
            for (int k = 1; k < SatDly; k++) begin
                sat_dly_reg[k] <= sat_dly_reg[k-1];
            end
        end
    end

    // Last stage of each path doubles as the output register
    assign m_tvalid = cordic_valid;
    assign m_tdata  = MDW'({sat_dly_reg[SatDly-1], hue, int_dly_reg[IntDly-1]});

endmodule

`default_nettype wire

// ===== sv/rihs_checker.sv =====
// ----------------------------------------------------------------------------
// rihs_checker
// Port-level assertions for the RGB to IHS pixel converter, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rihs_checker
    import rihs_pkg::*;
#(
    parameter int COMPONENT_BITS    = DEF_COMPONENT_BITS,
    parameter int HUE_FRACTION_BITS = DEF_HUE_FRACTION_BITS,
    parameter int SAT_FRACTION_BITS = DEF_SAT_FRACTION_BITS
) (
    input wire logic                                  aclk,
    input wire logic                                  aresetn,
    input wire logic                                  s_tvalid,
    input wire logic                                  s_tready,
    input wire logic [((3*COMPONENT_BITS+7)/8)*8-1:0] s_tdata,
    input wire logic                                  m_tvalid,
    input wire logic                                  m_tready,
    input wire logic [((2*COMPONENT_BITS+HUE_INT_BITS+HUE_FRACTION_BITS
                        +SAT_FRACTION_BITS+2+7)/8)*8-1:0] m_tdata
);

    localparam int IW = COMPONENT_BITS + 2;
    localparam int HW = HUE_INT_BITS + HUE_FRACTION_BITS;
    localparam logic [IW-1:0] IntMax  = IW'(4 * ((1 << COMPONENT_BITS) - 1));
    localparam logic [HW-1:0] HueFull = HW'(HUE_DEGREES << HUE_FRACTION_BITS);

    // Held result stays valid
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Held result keeps its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        $past(aresetn) == 1'b0 |-> !m_tvalid)
        else $error("result valid right after reset");

    a_int_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[IW-1:0] <= IntMax)
        else $error("intensity out of range");

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[IW+HW-1:IW] < HueFull)
        else $error("hue not wrapped below a full turn");

endmodule

bind rgb_to_ihs_pixel_converter rihs_checker #(
    .COMPONENT_BITS    (COMPONENT_BITS),
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS),
    .SAT_FRACTION_BITS (SAT_FRACTION_BITS)
) u_rihs_checker (.*);

`default_nettype wire
